>>> src/alu8_pkg.sv
// alu8_pkg: opcodes, flag and result types shared by the alu core and the top level
`default_nettype none

package alu8_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned OpW   = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_INC = 4'd3,
    OP_DEC = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_SHL = 4'd9,
    OP_SHR = 4'd10,
    OP_CMP = 4'd11
  } alu8_op_t;

  typedef struct packed {
    logic v;
    logic c;
    logic n;
    logic z;
  } alu8_flags_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    alu8_flags_t      flags;
    logic             keep;  // flags left as they were
  } alu8_res_t;

endpackage

`default_nettype wire

>>> src/alu8_core.sv
// alu8_core: combinational byte alu computing the result and the next flag value
`default_nettype none

module alu8_core (
  input  wire logic [alu8_pkg::OpW-1:0]   opcode,
  input  wire logic [alu8_pkg::DataW-1:0] operand_a,
  input  wire logic [alu8_pkg::DataW-1:0] operand_b,
  input  wire alu8_pkg::alu8_flags_t      flags_in,
  output alu8_pkg::alu8_res_t             res
);

  logic [alu8_pkg::DataW-1:0]   b_eff;
  logic [alu8_pkg::DataW:0]     sum;
  logic [alu8_pkg::DataW:0]     diff;
  logic [alu8_pkg::DataW-1:0]   prod;
  logic [2*alu8_pkg::DataW-1:0] shl_w;
  logic [2*alu8_pkg::DataW-1:0] shr_w;
  logic                         cnt_zero;
  logic                         cnt_big;
  logic                         add_v;
  logic                         sub_v;
  logic [alu8_pkg::DataW-1:0]   r;
  logic                         c;
  logic                         v;
  logic                         keep;

  // inc and dec use a constant one in place of b
  assign b_eff = (opcode == alu8_pkg::OP_INC || opcode == alu8_pkg::OP_DEC)
                 ? alu8_pkg::DataW'(1) : operand_b;

  assign sum  = {1'b0, operand_a} + {1'b0, b_eff};
  assign diff = {1'b0, operand_a} - {1'b0, b_eff};
  // only the low byte of the product is kept
  assign prod = operand_a * operand_b;

  assign add_v = (operand_a[7] == b_eff[7]) && (operand_a[7] != sum[7]);
  assign sub_v = (operand_a[7] != b_eff[7]) && (operand_a[7] != diff[7]);

  // count 1..8: shifted word carries result and last bit out side by side
  assign shl_w = {8'd0, operand_a} << operand_b[3:0];
  assign shr_w = {operand_a, 8'd0} >> operand_b[3:0];
  assign cnt_zero = (operand_b == '0);
  assign cnt_big  = (operand_b > alu8_pkg::DataW'(8));

  always_comb begin
    r    = '0;
    c    = 1'b0;
    v    = 1'b0;
    keep = 1'b0;
    unique case (alu8_pkg::alu8_op_t'(opcode))
      alu8_pkg::OP_ADD, alu8_pkg::OP_INC: begin
        r = sum[7:0];
        c = sum[8];
        v = add_v;
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_DEC, alu8_pkg::OP_CMP: begin
        r = diff[7:0];
        c = diff[8];
        v = sub_v;
      end
      alu8_pkg::OP_MUL: r = prod[7:0];
      alu8_pkg::OP_AND: r = operand_a & operand_b;
      alu8_pkg::OP_OR:  r = operand_a | operand_b;
      alu8_pkg::OP_XOR: r = operand_a ^ operand_b;
      alu8_pkg::OP_NOT: r = ~operand_a;
      alu8_pkg::OP_SHL: begin
        if (cnt_zero) begin
          r    = operand_a;
          keep = 1'b1;
        end else if (!cnt_big) begin
          r = shl_w[7:0];
          c = shl_w[8];
        end
      end
      alu8_pkg::OP_SHR: begin
        if (cnt_zero) begin
          r    = operand_a;
          keep = 1'b1;
        end else if (!cnt_big) begin
          r = shr_w[15:8];
          c = shr_w[7];
        end
      end
      default: keep = 1'b1;
    endcase
  end

  always_comb begin
    res.result = r;
    res.keep   = keep;
    if (keep) begin
      res.flags = flags_in;
    end else begin
      res.flags.z = (r == '0);
      res.flags.n = r[7];
      res.flags.c = c;
      res.flags.v = v;
    end
  end

endmodule

`default_nettype wire

>>> src/alu_8bit_nzcv_flags_unit.sv
// alu_8bit_nzcv_flags_unit: byte alu with held nzcv flags, input and result registers
`default_nettype none

// Takes one beat per cycle while the output is not stalled and returns one
// result beat for each: the opcode and operands are captured in an input
// register, the alu core works them out combinationally, and the result
// register loads the byte and the four flags at the same edge that updates
// the held flag register, so the next beat already sees those flags. Unused
// opcodes give a zero byte, and they and shifts by zero leave the flags as
// they were. Flags are zero after reset.
module alu_8bit_nzcv_flags_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [alu8_pkg::OpW-1:0]   in_opcode,
  input  wire logic [alu8_pkg::DataW-1:0] in_operand_a,
  input  wire logic [alu8_pkg::DataW-1:0] in_operand_b,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [alu8_pkg::DataW-1:0]      out_result_byte,
  output logic                            out_zero_flag,
  output logic                            out_negative_flag,
  output logic                            out_carry_flag,
  output logic                            out_overflow_flag
);

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic [alu8_pkg::OpW-1:0]   s1_op_r;
  logic [alu8_pkg::DataW-1:0] s1_a_r;
  logic [alu8_pkg::DataW-1:0] s1_b_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [alu8_pkg::DataW-1:0] out_result_r;
  alu8_pkg::alu8_flags_t      out_flags_r;
  alu8_pkg::alu8_flags_t      flags_r;
  alu8_pkg::alu8_res_t        core_res;
  logic                       out_free;
  logic                       s1_adv;
  logic                       in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  alu8_core u_core (
    .opcode    (s1_op_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .flags_in  (flags_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        flags_r <= core_res.flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_opcode;
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
    if (s1_adv) begin
      out_result_r <= core_res.result;
      out_flags_r  <= core_res.flags;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_byte   = out_result_r;
  assign out_zero_flag     = out_flags_r.z;
  assign out_negative_flag = out_flags_r.n;
  assign out_carry_flag    = out_flags_r.c;
  assign out_overflow_flag = out_flags_r.v;

  // a shown result always matches the held flags
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flags_r == flags_r))
    else $error("output flags differ from held flag register");

  // a beat leaving the input register shows up at the output next cycle
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach the output");

  // updated z and n follow the result byte
  a_zn_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !core_res.keep) |=>
      ((out_flags_r.z == (out_result_r == '0)) && (out_flags_r.n == out_result_r[7])))
    else $error("z or n flag inconsistent with result byte");

  // backpressure only with a beat waiting in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no beat waiting");

endmodule

`default_nettype wire
